// File: hdl/gapf_pkg.sv
// ============================================================================
// gapf_pkg
// Shared types and codes for the grid A* path finder.
// ============================================================================
package gapf_pkg;

    // Command codes
    localparam logic [1:0] CMD_WRITE = 2'd0;
    localparam logic [1:0] CMD_FIND  = 2'd1;
    localparam logic [1:0] CMD_POP   = 2'd2;
    localparam logic [1:0] CMD_NOP   = 2'd3;

    // Result status codes
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_NO_PATH  = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;
    localparam logic [1:0] ST_NO_STEP  = 2'd3;

    // Configuration register indexes
    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_OCC    = 2'd2;
    localparam logic [1:0] REG_RADIUS = 2'd3;

    // Neighbour directions, in trace order
    localparam logic [1:0] DIR_UP    = 2'd0;
    localparam logic [1:0] DIR_DOWN  = 2'd1;
    localparam logic [1:0] DIR_RIGHT = 2'd2;
    localparam logic [1:0] DIR_LEFT  = 2'd3;

    typedef enum logic [3:0] {
        S_IDLE,
        S_POP_WAIT,
        S_FIND_CHECK,
        S_CLEAR,
        S_INIT,
        S_QPOP,
        S_SCAN,
        S_SHIFT,
        S_DV_READ,
        S_DV_CHECK,
        S_NB_ISSUE,
        S_NB_CHECK,
        S_TRACE_ISSUE,
        S_TRACE_CHECK,
        S_FINISH
    } state_t;

    // Field write enables of the cell memory
    typedef struct packed {
        logic map_we;
        logic dist_we;
        logic path_we;
    } cell_we_t;

endpackage

// File: hdl/gapf_cell_mem.sv
// ============================================================================
// gapf_cell_mem
// Per-cell memory: wall and occupied bits, search distance and path slot,
// one shared write address with field enables, one registered read port.
// ============================================================================
module gapf_cell_mem
    import gapf_pkg::*;
#(
    parameter int XW    = 5,
    parameter int YW    = 5,
    parameter int DW    = 11,
    parameter int CW    = 10,
    parameter int CELLS = 1024
)
(
    input  logic          clk,
    input  cell_we_t      we,
    input  logic [CW-1:0] waddr,
    input  logic          wall_d,
    input  logic          occ_d,
    input  logic [DW-1:0] dist_d,
    input  logic [XW-1:0] px_d,
    input  logic [YW-1:0] py_d,
    input  logic [CW-1:0] raddr,
    output logic          wall_q,
    output logic          occ_q,
    output logic [DW-1:0] dist_q,
    output logic [XW-1:0] px_q,
    output logic [YW-1:0] py_q
);

    logic [1:0]       map_mem  [CELLS];
    logic [DW-1:0]    dist_mem [CELLS];
    logic [XW+YW-1:0] path_mem [CELLS];

    always_ff @(posedge clk)
    begin
        if (we.map_we)
        begin
            map_mem[waddr] <= {wall_d, occ_d};
        end
        if (we.dist_we)
        begin
            dist_mem[waddr] <= dist_d;
        end
        if (we.path_we)
        begin
            path_mem[waddr] <= {px_d, py_d};
        end
    end

    always_ff @(posedge clk)
    begin
        {wall_q, occ_q} <= map_mem[raddr];
        dist_q          <= dist_mem[raddr];
        {px_q, py_q}    <= path_mem[raddr];
    end

endmodule

// File: hdl/gapf_queue_mem.sv
// ============================================================================
// gapf_queue_mem
// Open-queue storage: one write port, one registered read port.
// ============================================================================
module gapf_queue_mem
#(
    parameter int QW    = 21,
    parameter int DEPTH = 2048,
    parameter int AW    = 11
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [QW-1:0] wdata,
    input  logic [AW-1:0] raddr,
    output logic [QW-1:0] rdata
);

    logic [QW-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/grid_astar_path_finder.sv
// ============================================================================
// grid_astar_path_finder
// A* search on a 4-connected grid held in on-chip memory.
// ============================================================================
// Commands arrive one item at a time on the cmd channel; each gives exactly
// one item on the res channel. A find with both endpoints inside the grid in
// use runs a clearing pass over all GRID_WIDTH * GRID_HEIGHT entries of the
// distance field, then for every queue pop a linear minimum scan and a
// compaction over the live queue entries through the single read port of
// the queue memory, plus neighbour reads on the cell memory unless the entry
// is stale, and once the goal is reached the trace back, step by step. All
// search state sits in the cell memory and the queue memory; each access is
// issued and checked in separate cycles, so a write never overlaps a read of
// the same entry. Configuration writes are taken in any cycle and must be
// made while idle.
module grid_astar_path_finder
    import gapf_pkg::*;
#(
    parameter int GRID_WIDTH  = 32,
    parameter int GRID_HEIGHT = 32,
    parameter int QUEUE_DEPTH = 2048
)
(
    input  logic       clk,
    input  logic       rst_n,
    // command channel
    input  logic       cmd_valid,
    output logic       cmd_stall,
    input  logic [1:0] command,
    input  logic [4:0] cell_x,
    input  logic [4:0] cell_y,
    input  logic       wall,
    input  logic       occupied,
    input  logic [4:0] goal_x,
    input  logic [4:0] goal_y,
    // result channel
    output logic       res_valid,
    input  logic       res_stall,
    output logic [1:0] status,
    output logic [9:0] path_length,
    output logic [4:0] step_x,
    output logic [4:0] step_y,
    output logic       last_step,
    // configuration channel
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [1:0] cfg_index,
    input  logic [5:0] cfg_data
);

    localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
    localparam int XW    = $clog2(GRID_WIDTH);
    localparam int YW    = $clog2(GRID_HEIGHT);
    localparam int CW    = $clog2(CELLS);
    localparam int DW    = CW + 1;          // distance, all ones is infinity
    localparam int KW    = DW;              // queue key
    localparam int QAW   = $clog2(QUEUE_DEPTH);
    localparam int QN    = QAW + 1;
    localparam int QW    = KW + XW + YW;
    localparam int CMPW  = (KW > 6) ? KW : 6;
    localparam logic [DW-1:0] DIST_INF = '1;

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------
    function automatic logic [KW-1:0] mdist(input logic [XW-1:0] ax,
                                            input logic [YW-1:0] ay,
                                            input logic [XW-1:0] bx,
                                            input logic [YW-1:0] by);
        logic [XW-1:0] dx;
        logic [YW-1:0] dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return KW'(dx) + KW'(dy);
    endfunction

    function automatic logic [CW-1:0] caddr(input logic [XW-1:0] x,
                                            input logic [YW-1:0] y);
        return CW'(32'(y) * GRID_WIDTH + 32'(x));
    endfunction

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    state_t         state_reg, state_next;

    logic [5:0]     width_cfg_reg, height_cfg_reg, radius_cfg_reg;
    logic           occ_cfg_reg;

    logic [4:0]     sx_reg, sy_reg, gx_reg, gy_reg;
    logic [4:0]     sx_next, sy_next, gx_next, gy_next;

    logic [CW-1:0]  clr_reg, clr_next;
    logic [QN-1:0]  qcount_reg, qcount_next;
    logic [QN-1:0]  scan_reg, scan_next;
    logic           cmp_v_reg, cmp_v_next;
    logic [QAW-1:0] cmp_idx_reg, cmp_idx_next;
    logic [QAW-1:0] best_idx_reg, best_idx_next;
    logic [KW-1:0]  e_key_reg, e_key_next;
    logic [XW-1:0]  e_x_reg, e_x_next;
    logic [YW-1:0]  e_y_reg, e_y_next;
    logic [QN-1:0]  sh_reg, sh_next;
    logic           shv_reg, shv_next;
    logic [QAW-1:0] shw_reg, shw_next;

    logic [DW-1:0]  dv_reg, dv_next;
    logic [1:0]     dir_reg, dir_next;
    logic [XW-1:0]  nb_x_reg, nb_x_next;
    logic [YW-1:0]  nb_y_reg, nb_y_next;

    logic [XW-1:0]  cur_x_reg, cur_x_next;
    logic [YW-1:0]  cur_y_reg, cur_y_next;
    logic [DW-1:0]  cur_dist_reg, cur_dist_next;
    logic [DW-1:0]  steps_reg, steps_next;
    logic [DW-1:0]  iter_reg, iter_next;
    logic [DW-1:0]  rem_reg, rem_next;

    // pending result, then output register
    logic [1:0]     pst_reg, pst_next;
    logic [9:0]     plen_reg, plen_next;
    logic [4:0]     px_reg, px_next, py_reg, py_next;
    logic           plast_reg, plast_next;

    logic           res_valid_reg;
    logic [1:0]     res_status_reg;
    logic [9:0]     res_len_reg;
    logic [4:0]     res_x_reg, res_y_reg;
    logic           res_last_reg;

    // ------------------------------------------------------------------
    // Memory ports
    // ------------------------------------------------------------------
    cell_we_t       c_we;
    logic [CW-1:0]  c_waddr, c_raddr;
    logic           c_wall_d, c_occ_d;
    logic [DW-1:0]  c_dist_d;
    logic [XW-1:0]  c_px_d;
    logic [YW-1:0]  c_py_d;
    logic           c_wall_q, c_occ_q;
    logic [DW-1:0]  c_dist_q;
    logic [XW-1:0]  c_px_q;
    logic [YW-1:0]  c_py_q;

    logic           q_we;
    logic [QAW-1:0] q_waddr, q_raddr;
    logic [QW-1:0]  q_wdata, q_rdata;
    logic [KW-1:0]  q_rkey;
    logic [XW-1:0]  q_rx;
    logic [YW-1:0]  q_ry;

    gapf_cell_mem #(
        .XW    (XW),
        .YW    (YW),
        .DW    (DW),
        .CW    (CW),
        .CELLS (CELLS)
    ) u_cell_mem (
        .clk    (clk),
        .we     (c_we),
        .waddr  (c_waddr),
        .wall_d (c_wall_d),
        .occ_d  (c_occ_d),
        .dist_d (c_dist_d),
        .px_d   (c_px_d),
        .py_d   (c_py_d),
        .raddr  (c_raddr),
        .wall_q (c_wall_q),
        .occ_q  (c_occ_q),
        .dist_q (c_dist_q),
        .px_q   (c_px_q),
        .py_q   (c_py_q)
    );

    gapf_queue_mem #(
        .QW    (QW),
        .DEPTH (QUEUE_DEPTH),
        .AW    (QAW)
    ) u_queue_mem (
        .clk   (clk),
        .we    (q_we),
        .waddr (q_waddr),
        .wdata (q_wdata),
        .raddr (q_raddr),
        .rdata (q_rdata)
    );

    assign {q_rkey, q_rx, q_ry} = q_rdata;

    // ------------------------------------------------------------------
    // Shared conditions
    // ------------------------------------------------------------------
    logic [XW:0]    w_eff;
    logic [YW:0]    h_eff;
    logic [XW-1:0]  sx_t, gx_t, base_x, nb_x_w;
    logic [YW-1:0]  sy_t, gy_t, base_y, nb_y_w;
    logic           accept, out_free, ends_ok;
    logic           scan_done, shift_done, stale, nb_inb;
    logic           blocked, nb_skip, nb_goal, q_full;
    logic           trace_done, trace_match, dir_last;
    logic [DW-1:0]  dv_inc;

    always_comb
    begin
        if (width_cfg_reg == 6'd0)
            w_eff = (XW+1)'(1);
        else if (32'(width_cfg_reg) > GRID_WIDTH)
            w_eff = (XW+1)'(GRID_WIDTH);
        else
            w_eff = (XW+1)'(width_cfg_reg);
        if (height_cfg_reg == 6'd0)
            h_eff = (YW+1)'(1);
        else if (32'(height_cfg_reg) > GRID_HEIGHT)
            h_eff = (YW+1)'(GRID_HEIGHT);
        else
            h_eff = (YW+1)'(height_cfg_reg);
    end

    assign sx_t = XW'(sx_reg);
    assign sy_t = YW'(sy_reg);
    assign gx_t = XW'(gx_reg);
    assign gy_t = YW'(gy_reg);

    assign accept    = cmd_valid && !cmd_stall;
    assign cmd_stall = (state_reg != S_IDLE);
    assign out_free  = !res_valid_reg || !res_stall;
    assign ends_ok   = (32'(sx_reg) < 32'(w_eff)) && (32'(sy_reg) < 32'(h_eff)) &&
                       (32'(gx_reg) < 32'(w_eff)) && (32'(gy_reg) < 32'(h_eff));

    assign scan_done  = (scan_reg == qcount_reg) && !cmp_v_reg;
    assign shift_done = (sh_reg == qcount_reg) && !shv_reg;
    assign stale      = (e_key_reg - mdist(e_x_reg, e_y_reg, gx_t, gy_t)) > KW'(c_dist_q);
    assign dir_last   = (dir_reg == DIR_LEFT);

    // neighbour of the expanded cell, or of the trace cursor
    always_comb
    begin
        if (state_reg == S_TRACE_ISSUE)
        begin
            base_x = cur_x_reg;
            base_y = cur_y_reg;
        end
        else
        begin
            base_x = e_x_reg;
            base_y = e_y_reg;
        end
        nb_x_w = base_x;
        nb_y_w = base_y;
        case (dir_reg)
            DIR_UP:
            begin
                nb_inb = (32'(base_y) + 1) < 32'(h_eff);
                nb_y_w = base_y + YW'(1);
            end
            DIR_DOWN:
            begin
                nb_inb = (base_y != '0);
                nb_y_w = base_y - YW'(1);
            end
            DIR_RIGHT:
            begin
                nb_inb = (32'(base_x) + 1) < 32'(w_eff);
                nb_x_w = base_x + XW'(1);
            end
            DIR_LEFT:
            begin
                nb_inb = (base_x != '0);
                nb_x_w = base_x - XW'(1);
            end
            default:
            begin
                nb_inb = 1'b0;
            end
        endcase
    end

    assign nb_goal = (nb_x_reg == gx_t) && (nb_y_reg == gy_t);
    assign blocked = c_wall_q ||
                     (occ_cfg_reg && c_occ_q && !nb_goal &&
                      (CMPW'(mdist(nb_x_reg, nb_y_reg, sx_t, sy_t)) < CMPW'(radius_cfg_reg)));
    assign dv_inc  = dv_reg + DW'(1);
    assign nb_skip = blocked || (dv_inc >= c_dist_q);
    assign q_full  = (qcount_reg == QN'(QUEUE_DEPTH));

    assign trace_done  = (iter_reg >= steps_reg) ||
                         ((cur_x_reg == sx_t) && (cur_y_reg == sy_t));
    assign trace_match = (c_dist_q != DIST_INF) &&
                         ({1'b0, cur_dist_reg} == ({1'b0, c_dist_q} + (DW+1)'(1)));

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    case (command)
                        CMD_FIND: state_next = S_FIND_CHECK;
                        CMD_POP:  state_next = (rem_reg == '0) ? S_FINISH : S_POP_WAIT;
                        default:  state_next = S_FINISH;
                    endcase
                end
            end
            S_POP_WAIT:   state_next = S_FINISH;
            S_FIND_CHECK: state_next = ends_ok ? S_CLEAR : S_FINISH;
            S_CLEAR:      state_next = (clr_reg == CW'(CELLS - 1)) ? S_INIT : S_CLEAR;
            S_INIT:       state_next = S_QPOP;
            S_QPOP:       state_next = (qcount_reg == '0) ? S_FINISH : S_SCAN;
            S_SCAN:       state_next = scan_done ? S_SHIFT : S_SCAN;
            S_SHIFT:      state_next = shift_done ? S_DV_READ : S_SHIFT;
            S_DV_READ:    state_next = S_DV_CHECK;
            S_DV_CHECK:   state_next = stale ? S_QPOP : S_NB_ISSUE;
            S_NB_ISSUE:
            begin
                if (nb_inb)
                    state_next = S_NB_CHECK;
                else if (dir_last)
                    state_next = S_QPOP;
            end
            S_NB_CHECK:
            begin
                if (!nb_skip && q_full)
                    state_next = S_FINISH;
                else if (!nb_skip && nb_goal)
                    state_next = S_TRACE_ISSUE;
                else if (dir_last)
                    state_next = S_QPOP;
                else
                    state_next = S_NB_ISSUE;
            end
            S_TRACE_ISSUE:
            begin
                if (trace_done)
                    state_next = S_FINISH;
                else if (nb_inb)
                    state_next = S_TRACE_CHECK;
            end
            S_TRACE_CHECK: state_next = S_TRACE_ISSUE;
            S_FINISH:      state_next = out_free ? S_IDLE : S_FINISH;
            default:       state_next = S_IDLE;
        endcase
    end

    // ------------------------------------------------------------------
    // Datapath and memory controls
    // ------------------------------------------------------------------
    always_comb
    begin
        sx_next       = sx_reg;
        sy_next       = sy_reg;
        gx_next       = gx_reg;
        gy_next       = gy_reg;
        clr_next      = clr_reg;
        qcount_next   = qcount_reg;
        scan_next     = scan_reg;
        cmp_v_next    = 1'b0;
        cmp_idx_next  = cmp_idx_reg;
        best_idx_next = best_idx_reg;
        e_key_next    = e_key_reg;
        e_x_next      = e_x_reg;
        e_y_next      = e_y_reg;
        sh_next       = sh_reg;
        shv_next      = 1'b0;
        shw_next      = shw_reg;
        dv_next       = dv_reg;
        dir_next      = dir_reg;
        nb_x_next     = nb_x_reg;
        nb_y_next     = nb_y_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        cur_dist_next = cur_dist_reg;
        steps_next    = steps_reg;
        iter_next     = iter_reg;
        rem_next      = rem_reg;
        pst_next      = pst_reg;
        plen_next     = plen_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        plast_next    = plast_reg;

        c_we     = '0;
        c_waddr  = '0;
        c_raddr  = '0;
        c_wall_d = wall;
        c_occ_d  = occupied;
        c_dist_d = DIST_INF;
        c_px_d   = cur_x_reg;
        c_py_d   = cur_y_reg;
        q_we     = 1'b0;
        q_waddr  = '0;
        q_raddr  = '0;
        q_wdata  = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    sx_next    = cell_x;
                    sy_next    = cell_y;
                    gx_next    = goal_x;
                    gy_next    = goal_y;
                    pst_next   = ST_OK;
                    plen_next  = '0;
                    px_next    = '0;
                    py_next    = '0;
                    plast_next = 1'b0;
                    case (command)
                        CMD_WRITE:
                        begin
                            if ((32'(cell_x) < GRID_WIDTH) && (32'(cell_y) < GRID_HEIGHT))
                            begin
                                c_we.map_we = 1'b1;
                                c_waddr     = caddr(XW'(cell_x), YW'(cell_y));
                            end
                        end
                        CMD_POP:
                        begin
                            if (rem_reg == '0)
                                pst_next = ST_NO_STEP;
                            else
                                c_raddr = CW'(rem_reg - DW'(1));
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            S_POP_WAIT:
            begin
                // read data is the popped step
                rem_next   = rem_reg - DW'(1);
                plen_next  = 10'(rem_reg - DW'(1));
                px_next    = 5'(c_px_q);
                py_next    = 5'(c_py_q);
                plast_next = (rem_reg == DW'(1));
            end
            S_FIND_CHECK:
            begin
                clr_next = '0;
                if (!ends_ok)
                    pst_next = ST_NO_PATH;
            end
            S_CLEAR:
            begin
                c_we.dist_we = 1'b1;
                c_waddr      = clr_reg;
                c_dist_d     = DIST_INF;
                clr_next     = clr_reg + CW'(1);
            end
            S_INIT:
            begin
                c_we.dist_we = 1'b1;
                c_waddr      = caddr(sx_t, sy_t);
                c_dist_d     = '0;
                q_we         = 1'b1;
                q_waddr      = '0;
                q_wdata      = {mdist(sx_t, sy_t, gx_t, gy_t), sx_t, sy_t};
                qcount_next  = QN'(1);
            end
            S_QPOP:
            begin
                scan_next = '0;
                if (qcount_reg == '0)
                    pst_next = ST_NO_PATH;
            end
            S_SCAN:
            begin
                // issue reads in order, compare each entry in the cycle after its read
                if (scan_reg != qcount_reg)
                begin
                    q_raddr      = QAW'(scan_reg);
                    scan_next    = scan_reg + QN'(1);
                    cmp_v_next   = 1'b1;
                    cmp_idx_next = QAW'(scan_reg);
                end
                if (cmp_v_reg && ((cmp_idx_reg == '0) || (q_rkey < e_key_reg)))
                begin
                    best_idx_next = cmp_idx_reg;
                    e_key_next    = q_rkey;
                    e_x_next      = q_rx;
                    e_y_next      = q_ry;
                end
                if (scan_done)
                    sh_next = QN'(best_idx_reg) + QN'(1);
            end
            S_SHIFT:
            begin
                // close the gap: read entry j+1, write it to j next cycle
                if (sh_reg != qcount_reg)
                begin
                    q_raddr  = QAW'(sh_reg);
                    sh_next  = sh_reg + QN'(1);
                    shv_next = 1'b1;
                    shw_next = QAW'(sh_reg - QN'(1));
                end
                if (shv_reg)
                begin
                    q_we    = 1'b1;
                    q_waddr = shw_reg;
                    q_wdata = q_rdata;
                end
                if (shift_done)
                    qcount_next = qcount_reg - QN'(1);
            end
            S_DV_READ:
            begin
                c_raddr = caddr(e_x_reg, e_y_reg);
            end
            S_DV_CHECK:
            begin
                dv_next  = c_dist_q;
                dir_next = DIR_UP;
            end
            S_NB_ISSUE:
            begin
                if (nb_inb)
                begin
                    nb_x_next = nb_x_w;
                    nb_y_next = nb_y_w;
                    c_raddr   = caddr(nb_x_w, nb_y_w);
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                end
            end
            S_NB_CHECK:
            begin
                dir_next = dir_reg + 2'd1;
                if (!nb_skip)
                begin
                    c_we.dist_we = 1'b1;
                    c_waddr      = caddr(nb_x_reg, nb_y_reg);
                    c_dist_d     = dv_inc;
                    if (q_full)
                    begin
                        pst_next = ST_OVERFLOW;
                    end
                    else
                    begin
                        q_we        = 1'b1;
                        q_waddr     = QAW'(qcount_reg);
                        q_wdata     = {KW'(dv_inc) + mdist(nb_x_reg, nb_y_reg, gx_t, gy_t),
                                       nb_x_reg, nb_y_reg};
                        qcount_next = qcount_reg + QN'(1);
                        if (nb_goal)
                        begin
                            steps_next    = dv_inc;
                            cur_x_next    = nb_x_reg;
                            cur_y_next    = nb_y_reg;
                            cur_dist_next = dv_inc;
                            iter_next     = '0;
                            dir_next      = DIR_UP;
                        end
                    end
                end
            end
            S_TRACE_ISSUE:
            begin
                if (trace_done)
                begin
                    rem_next  = steps_reg;
                    pst_next  = ST_OK;
                    plen_next = 10'(steps_reg);
                end
                else if (nb_inb)
                begin
                    nb_x_next = nb_x_w;
                    nb_y_next = nb_y_w;
                    c_raddr   = caddr(nb_x_w, nb_y_w);
                end
                else
                begin
                    dir_next = dir_reg + 2'd1;
                    if (dir_last)
                        iter_next = iter_reg + DW'(1);
                end
            end
            S_TRACE_CHECK:
            begin
                dir_next = dir_reg + 2'd1;
                if (trace_match)
                begin
                    // record the cursor and step to the predecessor
                    c_we.path_we  = 1'b1;
                    c_waddr       = CW'(steps_reg - cur_dist_reg);
                    c_px_d        = cur_x_reg;
                    c_py_d        = cur_y_reg;
                    cur_x_next    = nb_x_reg;
                    cur_y_next    = nb_y_reg;
                    cur_dist_next = c_dist_q;
                    iter_next     = iter_reg + DW'(1);
                    dir_next      = DIR_UP;
                end
                else if (dir_last)
                begin
                    iter_next = iter_reg + DW'(1);
                end
            end
            default:
            begin
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            width_cfg_reg  <= 6'd32;
            height_cfg_reg <= 6'd32;
            occ_cfg_reg    <= 1'b1;
            radius_cfg_reg <= 6'd6;
            qcount_reg     <= '0;
            rem_reg        <= '0;
            cmp_v_reg      <= 1'b0;
            shv_reg        <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            qcount_reg <= qcount_next;
            rem_reg    <= rem_next;
            cmp_v_reg  <= cmp_v_next;
            shv_reg    <= shv_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_WIDTH:  width_cfg_reg  <= cfg_data;
                    REG_HEIGHT: height_cfg_reg <= cfg_data;
                    REG_OCC:    occ_cfg_reg    <= cfg_data[0];
                    REG_RADIUS: radius_cfg_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            if (state_reg == S_FINISH && out_free)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        sx_reg       <= sx_next;
        sy_reg       <= sy_next;
        gx_reg       <= gx_next;
        gy_reg       <= gy_next;
        clr_reg      <= clr_next;
        scan_reg     <= scan_next;
        cmp_idx_reg  <= cmp_idx_next;
        best_idx_reg <= best_idx_next;
        e_key_reg    <= e_key_next;
        e_x_reg      <= e_x_next;
        e_y_reg      <= e_y_next;
        sh_reg       <= sh_next;
        shw_reg      <= shw_next;
        dv_reg       <= dv_next;
        dir_reg      <= dir_next;
        nb_x_reg     <= nb_x_next;
        nb_y_reg     <= nb_y_next;
        cur_x_reg    <= cur_x_next;
        cur_y_reg    <= cur_y_next;
        cur_dist_reg <= cur_dist_next;
        steps_reg    <= steps_next;
        iter_reg     <= iter_next;
        pst_reg      <= pst_next;
        plen_reg     <= plen_next;
        px_reg       <= px_next;
        py_reg       <= py_next;
        plast_reg    <= plast_next;
        if (state_reg == S_FINISH && out_free)
        begin
            res_status_reg <= pst_reg;
            res_len_reg    <= plen_reg;
            res_x_reg      <= px_reg;
            res_y_reg      <= py_reg;
            res_last_reg   <= plast_reg;
        end
    end

    assign res_valid   = res_valid_reg;
    assign status      = res_status_reg;
    assign path_length = res_len_reg;
    assign step_x      = res_x_reg;
    assign step_y      = res_y_reg;
    assign last_step   = res_last_reg;
    assign cfg_ready   = 1'b1;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_finish_loads: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FINISH && out_free) |=> res_valid_reg)
        else $error("result not loaded on finish");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted command did not start");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_NB_CHECK && q_we) |-> (qcount_reg < QN'(QUEUE_DEPTH)))
        else $error("queue push while full");

    a_pop_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_POP_WAIT) |-> (rem_reg != '0))
        else $error("path pop with no step left");

endmodule

// File: sim/tb_grid_astar_path_finder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_grid_astar_path_finder
// Self-checking bench for the grid A* path finder: a clocked driver feeds
// commands from a queue, an in-bench A* predictor computes each result, and a
// clocked monitor checks every result item field by field under random stalls.
// ----------------------------------------------------------------------------
module tb_grid_astar_path_finder;
    import gapf_pkg::*;

    localparam int GW        = 32;
    localparam int GH        = 32;
    localparam int QDEPTH    = 2048;
    localparam int CELLS     = GW * GH;
    localparam int DIST_NONE = 32'h7fffffff;
    localparam int WD_LIMIT  = 20000;
    localparam int AREA      = 6;                 // loaded block is AREA x AREA
    localparam int DX [4]    = '{0, 0, 1, -1};   // +y, -y, +x, -x
    localparam int DY [4]    = '{1, -1, 0, 0};

    typedef struct {
        logic [1:0] cmd;
        logic [4:0] cx;
        logic [4:0] cy;
        logic       wl;
        logic       oc;
        logic [4:0] gx;
        logic [4:0] gy;
    } cmd_item_t;

    typedef struct {
        logic [1:0] st;
        logic [9:0] len;
        logic [4:0] sx;
        logic [4:0] sy;
        logic       last;
    } res_item_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cmd_valid = 1'b0;
    logic       cmd_stall;
    logic [1:0] command = CMD_NOP;
    logic [4:0] cell_x = '0;
    logic [4:0] cell_y = '0;
    logic       wall = 1'b0;
    logic       occupied = 1'b0;
    logic [4:0] goal_x = '0;
    logic [4:0] goal_y = '0;
    logic       res_valid;
    logic       res_stall = 1'b0;
    logic [1:0] status;
    logic [9:0] path_length;
    logic [4:0] step_x;
    logic [4:0] step_y;
    logic       last_step;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [1:0] cfg_index = REG_WIDTH;
    logic [5:0] cfg_data = '0;

    grid_astar_path_finder uut (
        .clk(clk), .rst_n(rst_n),
        .cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .command(command),
        .cell_x(cell_x), .cell_y(cell_y), .wall(wall), .occupied(occupied),
        .goal_x(goal_x), .goal_y(goal_y),
        .res_valid(res_valid), .res_stall(res_stall), .status(status),
        .path_length(path_length), .step_x(step_x), .step_y(step_y),
        .last_step(last_step),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ---------------------------------------------------------------- model state
    bit  wall_m [CELLS];
    bit  occ_m  [CELLS];
    int  dist_m [CELLS];
    int  open_key  [QDEPTH];
    int  open_cell [QDEPTH];
    int  open_cnt;
    int  route_cells [CELLS];
    int  route_left;
    int  grid_w = 32;
    int  grid_h = 32;
    int  occ_rule = 1;
    int  near_radius = 6;

    cmd_item_t pending_q [$];
    res_item_t awaited_q [$];

    int  n_err = 0;
    int  n_items = 0;
    int  n_results = 0;
    int  n_found = 0;
    int  n_steps = 0;
    int  n_cfg = 0;
    bit  fast_mode = 1'b0;

    function automatic int manh(int ax, int ay, int bx, int by);
        return (ax > bx ? ax - bx : bx - ax) + (ay > by ? ay - by : by - ay);
    endfunction

    function automatic int clamp_dim(int v, int maxv);
        if (v == 0)
            return 1;
        return v > maxv ? maxv : v;
    endfunction

    // A* from (sx,sy) to (gx,gy); returns the status and sets the path length
    function automatic logic [1:0] astar_search(int sx, int sy, int gx, int gy,
                                                output int len);
        int w, h, start, goal, best, ek, ec, vx, vy, dv, tx, ty, t, cur, steps;
        bit found;
        w = clamp_dim(grid_w, GW);
        h = clamp_dim(grid_h, GH);
        len = 0;
        found = 0;
        if (sx >= w || sy >= h || gx >= w || gy >= h)
            return ST_NO_PATH;
        for (int i = 0; i < CELLS; i++)
            dist_m[i] = DIST_NONE;
        start = sy * GW + sx;
        goal  = gy * GW + gx;
        dist_m[start] = 0;
        open_key[0]  = manh(sx, sy, gx, gy);
        open_cell[0] = start;
        open_cnt = 1;
        while (open_cnt > 0 && !found)
        begin
            // take the lowest key, earliest entry on ties
            best = 0;
            for (int i = 1; i < open_cnt; i++)
                if (open_key[i] < open_key[best])
                    best = i;
            ek = open_key[best];
            ec = open_cell[best];
            for (int i = best; i < open_cnt - 1; i++)
            begin
                open_key[i]  = open_key[i + 1];
                open_cell[i] = open_cell[i + 1];
            end
            open_cnt--;
            vx = ec % GW;
            vy = ec / GW;
            dv = dist_m[ec];
            if (ek - manh(vx, vy, gx, gy) > dv)
                continue;
            for (int k = 0; k < 4; k++)
            begin
                tx = vx + DX[k];
                ty = vy + DY[k];
                if (tx < 0 || ty < 0 || tx >= w || ty >= h)
                    continue;
                t = ty * GW + tx;
                if (wall_m[t])
                    continue;
                if (occ_rule != 0 && occ_m[t] && t != goal &&
                    manh(tx, ty, sx, sy) < near_radius)
                    continue;
                if (dv + 1 >= dist_m[t])
                    continue;
                dist_m[t] = dv + 1;
                if (open_cnt >= QDEPTH)
                    return ST_OVERFLOW;
                open_key[open_cnt]  = dv + 1 + manh(tx, ty, gx, gy);
                open_cell[open_cnt] = t;
                open_cnt++;
                if (t == goal)
                begin
                    found = 1;
                    break;
                end
            end
        end
        if (!found)
            return ST_NO_PATH;
        // trace back from the goal through cells one step closer
        steps = dist_m[goal];
        cur = goal;
        for (int i = 0; i < steps && cur != start; i++)
        begin
            for (int k = 0; k < 4; k++)
            begin
                tx = cur % GW + DX[k];
                ty = cur / GW + DY[k];
                if (tx < 0 || ty < 0 || tx >= w || ty >= h)
                    continue;
                t = ty * GW + tx;
                if (dist_m[t] != DIST_NONE && dist_m[cur] == dist_m[t] + 1)
                begin
                    route_cells[steps - dist_m[cur]] = cur;
                    cur = t;
                    break;
                end
            end
        end
        route_left = steps;
        len = steps;
        return ST_OK;
    endfunction

    function automatic res_item_t predict_command(cmd_item_t it);
        res_item_t r;
        int len, c;
        r = '{st: ST_OK, len: '0, sx: '0, sy: '0, last: 1'b0};
        case (it.cmd)
            CMD_WRITE:
            begin
                wall_m[it.cy * GW + it.cx] = it.wl;
                occ_m[it.cy * GW + it.cx]  = it.oc;
            end
            CMD_FIND:
            begin
                r.st  = astar_search(it.cx, it.cy, it.gx, it.gy, len);
                r.len = len[9:0];
                if (r.st == ST_OK)
                    n_found++;
            end
            CMD_POP:
            begin
                if (route_left == 0)
                    r.st = ST_NO_STEP;
                else
                begin
                    c = route_cells[route_left - 1];
                    route_left--;
                    r.len  = route_left[9:0];
                    r.sx   = 5'(c % GW);
                    r.sy   = 5'(c / GW);
                    r.last = (route_left == 0);
                    n_steps++;
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    // ---------------------------------------------------------------- driver
    int send_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid <= 1'b0;
            send_gap = 0;
        end
        else
        begin
            cmd_item_t it;
            if (cmd_valid && !cmd_stall)
            begin
                it = '{cmd: command, cx: cell_x, cy: cell_y, wl: wall, oc: occupied,
                       gx: goal_x, gy: goal_y};
                awaited_q.push_back(predict_command(it));
                n_items++;
            end
            // the slot is free when nothing is offered or the offer just went in
            if (!cmd_valid || !cmd_stall)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    cmd_valid <= 1'b0;
                end
                else if (pending_q.size() != 0)
                begin
                    it = pending_q.pop_front();
                    command   <= it.cmd;
                    cell_x    <= it.cx;
                    cell_y    <= it.cy;
                    wall      <= it.wl;
                    occupied  <= it.oc;
                    goal_x    <= it.gx;
                    goal_y    <= it.gy;
                    cmd_valid <= 1'b1;
                    send_gap = fast_mode ? 0 : $urandom_range(0, 3);
                end
                else
                    cmd_valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------- monitor
    int  recv_gap;
    int  long_hold;
    bit  long_hold_done;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            recv_gap = 0;
            long_hold = 0;
            long_hold_done = 0;
        end
        else
        begin
            res_item_t w;
            if (res_valid && !res_stall)
            begin
                n_results++;
                if (awaited_q.size() == 0)
                begin
                    n_err++;
                    $display("%0t: result with nothing awaited: status %0d", $time, status);
                end
                else
                begin
                    w = awaited_q.pop_front();
                    if (status !== w.st || path_length !== w.len || step_x !== w.sx ||
                        step_y !== w.sy || last_step !== w.last)
                    begin
                        n_err++;
                        $display("%0t: mismatch expected st=%0d len=%0d x=%0d y=%0d last=%0d",
                                 $time, w.st, w.len, w.sx, w.sy, w.last);
                        $display("%0t:          actual   st=%0d len=%0d x=%0d y=%0d last=%0d",
                                 $time, status, path_length, step_x, step_y, last_step);
                    end
                end
                recv_gap = fast_mode ? 0 : $urandom_range(0, 3);
                // hold off once for a long stretch so the block backs up its input
                if (!long_hold_done && n_results == 20)
                begin
                    long_hold = 300;
                    long_hold_done = 1;
                end
            end
            if (long_hold > 0)
            begin
                long_hold--;
                res_stall <= 1'b1;
            end
            else if (recv_gap > 0)
            begin
                recv_gap--;
                res_stall <= 1'b1;
            end
            else
                res_stall <= 1'b0;
        end
    end

    // ---------------------------------------------------------------- watchdog
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WD_LIMIT)
        begin
            $display("%0t: watchdog expired", $time);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------- stimulus
    task automatic add_item(logic [1:0] cmd, int cx, int cy, int wl, int oc, int gx, int gy);
        pending_q.push_back('{cmd: cmd, cx: cx[4:0], cy: cy[4:0], wl: wl[0], oc: oc[0],
                              gx: gx[4:0], gy: gy[4:0]});
    endtask

    // hold until the block is idle and every result is in
    task automatic wait_drain();
        while (pending_q.size() != 0 || cmd_valid || awaited_q.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, int val);
        @(posedge clk);
        cfg_index <= idx;
        cfg_data  <= val[5:0];
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_WIDTH:  grid_w = val & 63;
            REG_HEIGHT: grid_h = val & 63;
            REG_OCC:    occ_rule = val & 1;
            default:    near_radius = val & 63;
        endcase
        n_cfg++;
        cfg_valid <= 1'b0;
    endtask

    task automatic set_config(int w, int h, int occ, int rad);
        write_reg(REG_WIDTH, w);
        write_reg(REG_HEIGHT, h);
        write_reg(REG_OCC, occ);
        write_reg(REG_RADIUS, rad);
    endtask

    // random traffic: mostly a find followed by pops, plus writes and noise
    task automatic random_phase(int n);
        int w, h, sel, pops;
        w = clamp_dim(grid_w, GW);
        h = clamp_dim(grid_h, GH);
        while (n > 0)
        begin
            sel = $urandom_range(0, 9);
            if (sel <= 4)
            begin
                add_item(CMD_FIND, $urandom_range(0, w - 1), $urandom_range(0, h - 1), 0, 0,
                         $urandom_range(0, w - 1), $urandom_range(0, h - 1));
                pops = $urandom_range(1, 4);
                repeat (pops) add_item(CMD_POP, $urandom, $urandom, $urandom, $urandom,
                                       $urandom, $urandom);
                n -= 1 + pops;
            end
            else if (sel <= 6)
            begin
                // keep rewrites inside the loaded block
                add_item(CMD_WRITE, $urandom_range(0, AREA - 1), $urandom_range(0, AREA - 1),
                         $urandom_range(0, 5) == 0, $urandom_range(0, 1), $urandom, $urandom);
                n--;
            end
            else if (sel == 7)
            begin
                // endpoints anywhere, often off the grid in use
                add_item(CMD_FIND, $urandom_range(0, 31), $urandom_range(0, 31), $urandom,
                         $urandom, $urandom_range(0, 31), $urandom_range(0, 31));
                n--;
            end
            else if (sel == 8)
            begin
                add_item(CMD_POP, 0, 0, 0, 0, 0, 0);
                n--;
            end
            else
            begin
                add_item(CMD_NOP, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
                n--;
            end
        end
        wait_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // pop before any search, then load the block every search below stays in;
        // a wall right of row 0 fences in the wide single-row searches
        add_item(CMD_POP, 0, 0, 0, 0, 0, 0);
        fast_mode = 1'b1;
        for (int y = 0; y < AREA; y++)
            for (int x = 0; x < AREA; x++)
                add_item(CMD_WRITE, x, y, $urandom_range(0, 6) == 0, $urandom_range(0, 4) == 0,
                         0, 0);
        add_item(CMD_WRITE, AREA, 0, 1, 0, 0, 0);
        wait_drain();
        fast_mode = 1'b0;

        // one step at the reset settings: the only open neighbour is the goal
        add_item(CMD_WRITE, 0, 1, 1, 0, 0, 0);
        add_item(CMD_WRITE, 1, 0, 0, 0, 0, 0);
        add_item(CMD_FIND, 0, 0, 0, 0, 1, 0);
        repeat (2) add_item(CMD_POP, 0, 0, 0, 0, 0, 0);
        wait_drain();

        // directed cases inside the loaded block
        set_config(AREA, AREA, 1, 6);
        add_item(CMD_NOP, 31, 31, 1, 1, 31, 31);
        add_item(CMD_FIND, 2, 2, 0, 0, 2, 2);                 // start equals goal
        add_item(CMD_WRITE, 0, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 5, 5, 0, 0, 0, 0);
        add_item(CMD_FIND, 0, 0, 0, 0, 5, 5);                 // corner to corner
        repeat (3) add_item(CMD_POP, 0, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 4, 5, 1, 1, 0, 0);
        add_item(CMD_FIND, 2, 5, 0, 0, 4, 5);                 // goal is a wall
        add_item(CMD_POP, 0, 0, 0, 0, 0, 0);                  // old path still there
        add_item(CMD_WRITE, 3, 0, 0, 1, 0, 0);
        add_item(CMD_WRITE, 2, 0, 0, 0, 0, 0);
        add_item(CMD_WRITE, 1, 0, 0, 0, 0, 0);
        add_item(CMD_FIND, 0, 0, 0, 0, 3, 0);                 // occupied goal
        add_item(CMD_WRITE, 1, 1, 1, 1, 0, 0);
        add_item(CMD_FIND, 1, 1, 0, 0, 3, 1);                 // walled start
        repeat (5) add_item(CMD_POP, 0, 0, 0, 0, 0, 0);       // run past the end
        wait_drain();

        // settings sweep, extremes included
        set_config(AREA, 4, 1, 2);
        add_item(CMD_FIND, 9, 0, 0, 0, 0, 0);                 // start off the grid
        random_phase(8);
        set_config(0, 5, 0, 63);
        random_phase(5);
        set_config(5, 3, 1, 63);
        random_phase(6);
        // width above the grid, one row: searches stop at the fence wall
        set_config(63, 1, 1, 0);
        add_item(CMD_FIND, 0, 0, 0, 0, 5, 0);
        repeat (2) add_item(CMD_POP, 0, 0, 0, 0, 0, 0);
        add_item(CMD_FIND, 0, 0, 0, 0, 9, 0);
        wait_drain();
        set_config(AREA, AREA, 0, 6);
        random_phase(6);
        set_config(AREA, AREA, 1, 1);
        random_phase(6);

        repeat (50) @(posedge clk);
        if (awaited_q.size() != 0)
        begin
            n_err++;
            $display("%0t: %0d results never arrived", $time, awaited_q.size());
        end
        $display("Covered %0d commands, %0d results, %0d register writes.",
                 n_items, n_results, n_cfg);
        $display("Searches that found a path: %0d, path steps popped: %0d.", n_found, n_steps);
        if (n_err == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// File: grid_astar_path_finder.f
hdl/gapf_pkg.sv
hdl/gapf_cell_mem.sv
hdl/gapf_queue_mem.sv
hdl/grid_astar_path_finder.sv
sim/tb_grid_astar_path_finder.sv
